// ===== rtl/hpm_pkg.sv =====
// Shared types and constants for the H-bridge drive mixer.
package hpm_pkg;

  // Field widths fixed by the command and compare formats.
  localparam int unsigned CmdW   = 16;
  localparam int unsigned RegW   = 11;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DriveW = 13;
  localparam int unsigned CurveW = 16;

  // Deadband curve coefficients in Q1.24.
  localparam int unsigned FracBits = 24;
  localparam logic [14:0] COEF_A = 15'd22443;
  localparam logic signed [24:0] COEF_B = -25'sd9256395;

  // Register indexes on the configuration port.
  typedef enum logic [RegIdxW-1:0] {
    REG_TURN_SIGN    = 3'd0,
    REG_DRIVE_ENABLE = 3'd1,
    REG_LOW_BAND     = 3'd2,
    REG_START_OFFSET = 3'd3,
    REG_TOP_LIMIT    = 3'd4
  } hpm_reg_e;

  // Live configuration handed to every stage.
  typedef struct packed {
    logic            turn_sign;
    logic            drive_enable;
    logic [RegW-1:0] low_band;
    logic [RegW-1:0] start_offset;
    logic [RegW-1:0] top_limit;
  } hpm_cfg_t;

endpackage

// ===== rtl/hpm_scale.sv =====
// Two-stage scaling of the balance and turn commands and their signed sum.
module hpm_scale
  import hpm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hpm_cfg_t                 cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CmdW-1:0]   balance_cmd_i,
  input  logic signed [CmdW-1:0]   turn_cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DriveW-1:0] drive_o
);

  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;
  logic signed [27:0] bal_prod_d, bal_prod_q, trn_prod_d, trn_prod_q;
  logic signed [27:0] bal_bias, trn_bias;
  logic signed [11:0] bal_scaled, trn_scaled;
  logic signed [DriveW-1:0] drive_d, drive_q;

  // A stage takes a new transfer when it is empty or its contents move on.
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage one: multiply both commands by the top limit.
  assign bal_prod_d = 28'(balance_cmd_i) * 28'($signed({1'b0, cfg_i.top_limit}));
  assign trn_prod_d = 28'(turn_cmd_i) * 28'($signed({1'b0, cfg_i.top_limit}));

  // Stage two: divide by 2^15 rounding toward zero, then add or subtract the turn term.
  assign bal_bias   = bal_prod_q + (bal_prod_q[27] ? 28'sd32767 : 28'sd0);
  assign trn_bias   = trn_prod_q + (trn_prod_q[27] ? 28'sd32767 : 28'sd0);
  assign bal_scaled = bal_bias[26:15];
  assign trn_scaled = trn_bias[26:15];
  assign drive_d    = cfg_i.turn_sign
                      ? {bal_scaled[11], bal_scaled} - {trn_scaled[11], trn_scaled}
                      : {bal_scaled[11], bal_scaled} + {trn_scaled[11], trn_scaled};

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      bal_prod_q <= bal_prod_d;
      trn_prod_q <= trn_prod_d;
    end
    if (s2_ready && s1_valid_q) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign drive_o     = drive_q;

endmodule

// ===== rtl/hpm_curve.sv =====
// Three-stage deadband compensation curve applied to drive values inside the low band.
module hpm_curve
  import hpm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hpm_cfg_t                 cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DriveW-1:0] drive_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CurveW-1:0] value_o
);

  logic s3_valid_q, s4_valid_q, s5_valid_q;
  logic s3_ready, s4_ready, s5_ready;

  // Stage three signals.
  logic [DriveW-1:0] mag_abs;
  logic [RegW-1:0]   mag_low;
  logic              in_band_d;
  logic [21:0]       sq_d, sq_q;
  logic signed [36:0] bm_d, bm_q, bm_s4_q;
  logic signed [DriveW-1:0] drive_s3_q, drive_s4_q;
  logic in_band_s3_q, in_band_s4_q;
  logic neg_s3_q, neg_s4_q;

  // Stage four signals.
  logic [36:0]        asq;
  logic signed [39:0] poly_d, poly_q;

  // Stage five signals.
  logic signed [39:0]       poly_bias;
  logic signed [CurveW-1:0] curve_mag, curve_val, value_d, value_q;

  // Ready chain: each stage advances when empty or when the next one takes its transfer.
  assign s5_ready   = !s5_valid_q || out_ready_i;
  assign s4_ready   = !s4_valid_q || s5_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  // Stage three: magnitude, band test, square and linear term on the magnitude.
  // The negative branch of the curve is the positive branch mirrored through zero.
  assign mag_abs   = drive_i[DriveW-1] ? DriveW'(-drive_i) : DriveW'(drive_i);
  assign mag_low   = mag_abs[RegW-1:0];
  assign in_band_d = mag_abs < {2'b00, cfg_i.low_band};
  assign sq_d      = 22'(mag_low) * 22'(mag_low);
  assign bm_d      = 37'(COEF_B) * 37'($signed({1'b0, mag_low}));

  // Stage four: quadratic term plus linear term plus the start offset.
  assign asq    = 37'(COEF_A) * 37'(sq_q);
  assign poly_d = $signed({3'b000, asq}) + $signed({{3{bm_s4_q[36]}}, bm_s4_q})
                  + $signed({5'b00000, cfg_i.start_offset, 24'd0});

  // Stage five: drop the fraction toward zero, restore the sign, pick curve or raw value.
  assign poly_bias = poly_q + (poly_q[39] ? 40'sd16777215 : 40'sd0);
  assign curve_mag = poly_bias[FracBits+CurveW-1:FracBits];
  assign curve_val = neg_s4_q ? -curve_mag : curve_mag;
  assign value_d   = in_band_s4_q ? curve_val
                                  : {{(CurveW-DriveW){drive_s4_q[DriveW-1]}}, drive_s4_q};

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= in_valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      sq_q         <= sq_d;
      bm_q         <= bm_d;
      drive_s3_q   <= drive_i;
      in_band_s3_q <= in_band_d;
      neg_s3_q     <= drive_i[DriveW-1];
    end
    if (s4_ready && s3_valid_q) begin
      poly_q       <= poly_d;
      drive_s4_q   <= drive_s3_q;
      in_band_s4_q <= in_band_s3_q;
      neg_s4_q     <= neg_s3_q;
    end
    if (s5_ready && s4_valid_q) begin
      value_q <= value_d;
    end
  end

  // The linear term only joins the sum in stage four, so keep it aligned with the square.
  assign bm_s4_q = bm_q;

  assign out_valid_o = s5_valid_q;
  assign value_o     = value_q;

endmodule

// ===== rtl/hpm_drive.sv =====
// Output stage: clamp to the top limit, split into sign and magnitude, select channel compares.
module hpm_drive
  import hpm_pkg::*;
#(
  parameter int unsigned COMPARE_WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hpm_cfg_t                 cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CurveW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RegW-1:0]          ch_a_compare_o,
  output logic [RegW-1:0]          ch_b_compare_o,
  output logic signed [1:0]        drive_sign_o,
  output logic [RegW-1:0]          duty_magnitude_o
);

  logic valid_q;
  logic signed [CurveW-1:0] top_s, clamped;
  logic [RegW-1:0] mag;
  logic signed [1:0] sign_d;
  logic [COMPARE_WIDTH-1:0] cmp_mag, cmp_band, cmp_a, cmp_b;
  logic [RegW-1:0] ch_a_q, ch_b_q, mag_q;
  logic signed [1:0] sign_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // Saturate to plus or minus the top limit.
  assign top_s = $signed({{(CurveW-RegW){1'b0}}, cfg_i.top_limit});
  always_comb begin
    clamped = value_i;
    if (clamped >= top_s) begin
      clamped = top_s;
    end
    if (clamped <= -top_s) begin
      clamped = -top_s;
    end
  end

  // Sign and magnitude of the clamped drive value.
  assign mag    = clamped[CurveW-1] ? RegW'(-clamped) : RegW'(clamped);
  assign sign_d = clamped[CurveW-1] ? -2'sd1 : ((clamped != '0) ? 2'sd1 : 2'sd0);

  // Channel compares: forward, reverse, brake at the band value, or all off.
  assign cmp_mag  = COMPARE_WIDTH'(mag);
  assign cmp_band = COMPARE_WIDTH'(cfg_i.low_band);
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    if (cfg_i.drive_enable) begin
      if (sign_d == 2'sd0) begin
        cmp_a = cmp_band;
        cmp_b = cmp_band;
      end else if (sign_d == 2'sd1) begin
        cmp_a = cmp_mag;
      end else begin
        cmp_b = cmp_mag;
      end
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_a_q <= cmp_a[RegW-1:0];
      ch_b_q <= cmp_b[RegW-1:0];
      sign_q <= sign_d;
      mag_q  <= mag;
    end
  end

  assign out_valid_o      = valid_q;
  assign ch_a_compare_o   = ch_a_q;
  assign ch_b_compare_o   = ch_b_q;
  assign drive_sign_o     = sign_q;
  assign duty_magnitude_o = mag_q;

  // Both channels are only driven together when braking.
  a_brake_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ch_a_q != '0 && ch_b_q != '0 |-> ch_a_q == ch_b_q && sign_q == 2'sd0)
    else $error("both channels driven outside brake");

  // A stopped drive has zero magnitude, a moving drive a nonzero one.
  a_stop_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (sign_q == 2'sd0) == (mag_q == '0))
    else $error("sign and magnitude disagree");

  // The sign code never takes the unused pattern.
  a_sign_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> sign_q != 2'b10)
    else $error("invalid sign code");

  // A forward drive never drives the reverse channel, and the other way round.
  a_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && sign_q != 2'sd0 |-> ch_a_q == '0 || ch_b_q == '0)
    else $error("both channels driven while moving");

endmodule

// ===== rtl/hbridge_pwm_mixer_deadband.sv =====
// Top level of the H-bridge drive mixer with deadband compensation.
//
// Each transfer on the command channel carries a balance and a turn command in Q1.15; both are
// scaled by the top limit, summed (the turn term with the configured sign), remapped through a
// quadratic deadband curve inside the low band, clamped to the top limit and turned into a pair
// of half-bridge compare values plus sign and magnitude. The datapath is a six-stage pipeline
// (two scaling stages, three curve stages and the output register). One command pair is taken
// every cycle while the output accepts results; each stage advances on its own, so a stall at
// the output fills empty stages before it holds the input. The configuration registers are
// written through a plain write port and must only change while no command is in flight.
module hbridge_pwm_mixer_deadband
  import hpm_pkg::*;
#(
  parameter int unsigned COMPARE_WIDTH = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [RegIdxW-1:0]      cfg_idx_i,
  input  logic [RegW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CmdW-1:0]  balance_cmd_i,
  input  logic signed [CmdW-1:0]  turn_cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [RegW-1:0]         ch_a_compare_o,
  output logic [RegW-1:0]         ch_b_compare_o,
  output logic signed [1:0]       drive_sign_o,
  output logic [RegW-1:0]         duty_magnitude_o
);

  hpm_cfg_t cfg_q;
  logic scale_valid, scale_ready;
  logic signed [DriveW-1:0] drive;
  logic curve_valid, curve_ready;
  logic signed [CurveW-1:0] curve_value;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_sign    <= 1'b0;
      cfg_q.drive_enable <= 1'b0;
      cfg_q.low_band     <= 11'd580;
      cfg_q.start_offset <= 11'd450;
      cfg_q.top_limit    <= 11'd1900;
    end else if (cfg_we_i) begin
      case (hpm_reg_e'(cfg_idx_i))
        REG_TURN_SIGN:    cfg_q.turn_sign    <= cfg_wdata_i[0];
        REG_DRIVE_ENABLE: cfg_q.drive_enable <= cfg_wdata_i[0];
        REG_LOW_BAND:     cfg_q.low_band     <= cfg_wdata_i;
        REG_START_OFFSET: cfg_q.start_offset <= cfg_wdata_i;
        REG_TOP_LIMIT:    cfg_q.top_limit    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Scaling and mixing.
  hpm_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .balance_cmd_i (balance_cmd_i),
    .turn_cmd_i    (turn_cmd_i),
    .out_valid_o   (scale_valid),
    .out_ready_i   (scale_ready),
    .drive_o       (drive)
  );

  // Deadband compensation curve.
  hpm_curve u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (scale_valid),
    .in_ready_o  (scale_ready),
    .drive_i     (drive),
    .out_valid_o (curve_valid),
    .out_ready_i (curve_ready),
    .value_o     (curve_value)
  );

  // Clamp, direction and compare selection.
  hpm_drive #(
    .COMPARE_WIDTH (COMPARE_WIDTH)
  ) u_drive (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (curve_valid),
    .in_ready_o       (curve_ready),
    .value_i          (curve_value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ch_a_compare_o   (ch_a_compare_o),
    .ch_b_compare_o   (ch_b_compare_o),
    .drive_sign_o     (drive_sign_o),
    .duty_magnitude_o (duty_magnitude_o)
  );

endmodule
